// ===== hdl/cffba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffba_pkg
// Shared types and codes of the contiguous first-fit block allocator.
// ----------------------------------------------------------------------------
package cffba_pkg;

  // fixed field widths
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned ACTION_W = 1;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned START_W  = 6;

  // reset value of the managed block count
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // request codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_RUN   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_HELD = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IN_USE   = 2'd3;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_RESP
  } state_t;

  // controls broadcast to every cell of the row
  typedef struct packed {
    logic scan_keep;  // token may advance this cycle
    logic paint_en;   // update used marks inside the range
    logic paint_set;  // value written into the used marks
  } cell_ctrl_t;

endpackage

// ===== hdl/contiguous_first_fit_block_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_first_fit_block_allocator_core
// First-fit allocator of contiguous block runs with an id-indexed run table.
// ----------------------------------------------------------------------------
// Each word in gives one word out. A free, or any request that is refused
// before a search, passes from the lookup state straight to the response
// state and its result word goes into the output register. An allocate
// sends a token down the row of block cells, one block per cycle, until a
// cell reports a fitting run or the last managed block has been examined.
// The block takes one request at a time; a new word is accepted while the
// last result still waits at the output register, and only a result that
// is ready while the previous one still waits holds the sequencer. No
// clearing pass is needed after reset.
module contiguous_first_fit_block_allocator_core #(
  parameter int unsigned NUM_BLOCKS = 64,
  parameter int unsigned MAX_IDS    = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [cffba_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cffba_pkg::ACTION_W-1:0]  in_action,
  input  logic [cffba_pkg::ID_W-1:0]      in_file_id,
  input  logic [cffba_pkg::LEN_W-1:0]     in_length,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cffba_pkg::STATUS_W-1:0]  out_status,
  output logic [cffba_pkg::START_W-1:0]   out_start_block
);

  localparam int unsigned IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned PW      = $clog2(NUM_BLOCKS + 127);
  localparam int unsigned CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned LIM_W   = (CNT_W > cffba_pkg::CFG_W) ? CNT_W : cffba_pkg::CFG_W;
  localparam int unsigned IDW     = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int unsigned IDEXT_W = (IDW > cffba_pkg::ID_W) ? IDW : cffba_pkg::ID_W;
  localparam int unsigned ENT_W   = IDX_W + cffba_pkg::LEN_W;

  // configuration register
  logic [cffba_pkg::CFG_W-1:0] cfg_r;
  logic [LIM_W-1:0]            cfg_ext;
  logic [LIM_W-1:0]            limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cffba_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  assign cfg_ext = LIM_W'(cfg_r);
  assign limit   = (cfg_ext > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : cfg_ext;

  // request registers
  cffba_pkg::state_t               state_r, state_nxt;
  logic [cffba_pkg::ACTION_W-1:0]  act_r;
  logic [IDEXT_W-1:0]              id_r;
  logic [cffba_pkg::LEN_W-1:0]     len_r;
  logic [IDX_W-1:0]                idx_r, idx_nxt;
  logic [cffba_pkg::STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [cffba_pkg::START_W-1:0]   res_start_r, res_start_nxt;
  logic                            accept;
  logic [IDEXT_W-1:0]              in_id_ext;
  logic [IDW-1:0]                  id_idx;
  logic                            id_ok;

  assign in_ready  = (state_r == cffba_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_id_ext = IDEXT_W'(in_file_id);
  assign id_idx    = id_r[IDW-1:0];
  // one spare bit so that the id count itself fits
  assign id_ok     = ((IDEXT_W+1)'(id_r) < (IDEXT_W+1)'(MAX_IDS));

  // run table: valid marks in flops, start and length in a memory
  logic [MAX_IDS-1:0] valid_r;
  logic [ENT_W-1:0]   entry_mem [MAX_IDS];
  logic [ENT_W-1:0]   rd_r;
  logic [IDX_W-1:0]   rd_start;
  logic [cffba_pkg::LEN_W-1:0] rd_len;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_start;
  logic               vset, vclr;

  assign rd_start = rd_r[ENT_W-1:cffba_pkg::LEN_W];
  assign rd_len   = rd_r[cffba_pkg::LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= entry_mem[in_id_ext[IDW-1:0]];
    end
    if (mem_we) begin
      entry_mem[id_idx] <= {wr_start, len_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (vset) begin
      valid_r[id_idx] <= 1'b1;
    end else if (vclr) begin
      valid_r[id_idx] <= 1'b0;
    end
  end

  // cell row
  cffba_pkg::cell_ctrl_t ctrl;
  logic [PW-1:0]         paint_lo, paint_hi;
  logic                  inject;
  logic                  hit_any;

  cffba_chain #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .PW         (PW)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .paint_lo (paint_lo),
    .paint_hi (paint_hi),
    .req_len  (len_r),
    .inject   (inject),
    .hit_any  (hit_any)
  );

  // scan position helpers
  logic [PW-1:0]    scan_end;
  logic [PW-1:0]    found_start;
  logic [PW-1:0]    free_start;
  logic             last_block;

  assign scan_end    = PW'(idx_r) + PW'(1);
  assign found_start = scan_end - PW'(len_r);
  assign free_start  = PW'(rd_start);
  assign last_block  = ((LIM_W'(idx_r) + LIM_W'(1)) == limit);
  assign wr_start    = found_start[IDX_W-1:0];

  // output register
  logic                           out_valid_r;
  logic [cffba_pkg::STATUS_W-1:0] out_status_r;
  logic [cffba_pkg::START_W-1:0]  out_start_r;
  logic                           load_out;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    inject         = 1'b0;
    ctrl           = '0;
    paint_lo       = '0;
    paint_hi       = '0;
    mem_we         = 1'b0;
    vset           = 1'b0;
    vclr           = 1'b0;
    load_out       = 1'b0;
    unique case (state_r)
      cffba_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = cffba_pkg::S_LOOKUP;
        end
      end
      cffba_pkg::S_LOOKUP: begin
        state_nxt     = cffba_pkg::S_RESP;
        res_start_nxt = '0;
        priority if (!id_ok) begin
          res_status_nxt = cffba_pkg::ST_NOT_HELD;
        end else if (act_r == cffba_pkg::ACT_ALLOC) begin
          priority if (valid_r[id_idx]) begin
            res_status_nxt = cffba_pkg::ST_IN_USE;
          end else if (len_r == '0 || limit == '0) begin
            res_status_nxt = cffba_pkg::ST_NO_RUN;
          end else begin
            inject         = 1'b1;
            ctrl.scan_keep = 1'b1;
            idx_nxt        = '0;
            state_nxt      = cffba_pkg::S_SCAN;
          end
        end else if (!valid_r[id_idx]) begin
          res_status_nxt = cffba_pkg::ST_NOT_HELD;
        end else begin
          // release the recorded run
          ctrl.paint_en  = 1'b1;
          ctrl.paint_set = 1'b0;
          paint_lo       = free_start;
          paint_hi       = free_start + PW'(rd_len);
          vclr           = 1'b1;
          res_status_nxt = cffba_pkg::ST_OK;
          res_start_nxt  = free_start[cffba_pkg::START_W-1:0];
        end
      end
      cffba_pkg::S_SCAN: begin
        priority if (hit_any) begin
          // claim the run that ends at the current block
          ctrl.paint_en  = 1'b1;
          ctrl.paint_set = 1'b1;
          paint_lo       = found_start;
          paint_hi       = scan_end;
          mem_we         = 1'b1;
          vset           = 1'b1;
          res_status_nxt = cffba_pkg::ST_OK;
          res_start_nxt  = found_start[cffba_pkg::START_W-1:0];
          state_nxt      = cffba_pkg::S_RESP;
        end else if (last_block) begin
          res_status_nxt = cffba_pkg::ST_NO_RUN;
          res_start_nxt  = '0;
          state_nxt      = cffba_pkg::S_RESP;
        end else begin
          ctrl.scan_keep = 1'b1;
          idx_nxt        = idx_r + IDX_W'(1);
        end
      end
      cffba_pkg::S_RESP: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = cffba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cffba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cffba_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      id_r  <= in_id_ext;
      len_r <= in_length;
    end
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status_r;
      out_start_r  <= res_start_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_start_block = out_start_r;

  // a fit found in the scan holds the id afterwards
  a_hold_after_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cffba_pkg::S_SCAN && hit_any) |=> valid_r[id_idx])
    else $error("id not held after a successful allocate");

  // the token never examines a block outside the managed range
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cffba_pkg::S_SCAN) |-> (LIM_W'(idx_r) < limit))
    else $error("scan beyond the managed blocks");

  // a refused request reports block zero
  a_fail_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != cffba_pkg::ST_OK) |-> (out_start_r == '0))
    else $error("failed request reports a nonzero start block");

endmodule

// ===== hdl/cffba_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffba_cell
// One block of the store: its used mark and a stage of the scan token.
// ----------------------------------------------------------------------------
module cffba_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned PW    = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cffba_pkg::cell_ctrl_t        ctrl,
  input  logic [PW-1:0]                paint_lo,
  input  logic [PW-1:0]                paint_hi,
  input  logic [cffba_pkg::LEN_W-1:0]  req_len,
  input  logic                         tok_in,
  input  logic [cffba_pkg::LEN_W-1:0]  run_in,
  output logic                         tok_out,
  output logic [cffba_pkg::LEN_W-1:0]  run_out,
  output logic                         hit
);

  logic                        used_r;
  logic                        tok_r;
  logic [cffba_pkg::LEN_W-1:0] run_r;
  logic [cffba_pkg::LEN_W-1:0] run_here;
  logic                        in_range;

  // run of free blocks ending at this cell
  assign run_here = used_r ? '0 : run_r + cffba_pkg::LEN_W'(1);
  assign hit      = tok_r && !used_r && (run_here == req_len);
  assign tok_out  = tok_r && !hit;
  assign run_out  = run_here;

  assign in_range = (PW'(INDEX) >= paint_lo) && (PW'(INDEX) < paint_hi);

  // used mark and token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      tok_r <= tok_in && ctrl.scan_keep;
      if (ctrl.paint_en && in_range) begin
        used_r <= ctrl.paint_set;
      end
    end
  end

  // run count travels with the token
  always_ff @(posedge clk) begin
    run_r <= run_in;
  end

endmodule

// ===== hdl/cffba_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffba_chain
// Row of block cells; the scan token walks one cell per cycle.
// ----------------------------------------------------------------------------
module cffba_chain #(
  parameter int unsigned NUM_BLOCKS = 64,
  parameter int unsigned PW         = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cffba_pkg::cell_ctrl_t        ctrl,
  input  logic [PW-1:0]                paint_lo,
  input  logic [PW-1:0]                paint_hi,
  input  logic [cffba_pkg::LEN_W-1:0]  req_len,
  input  logic                         inject,
  output logic                         hit_any
);

  logic [NUM_BLOCKS:0]                tok;
  logic [cffba_pkg::LEN_W-1:0]        run [NUM_BLOCKS+1];
  logic [NUM_BLOCKS-1:0]              hit;

  // token enters at block 0 with an empty run
  assign tok[0] = inject;
  assign run[0] = '0;

  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    cffba_cell #(
      .INDEX (i),
      .PW    (PW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .paint_lo (paint_lo),
      .paint_hi (paint_hi),
      .req_len  (req_len),
      .tok_in   (tok[i]),
      .run_in   (run[i]),
      .tok_out  (tok[i+1]),
      .run_out  (run[i+1]),
      .hit      (hit[i])
    );
  end

  assign hit_any = |hit;

  // only the cell holding the token can report a fit
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit))
    else $error("more than one cell reports a fitting run");

endmodule

// ===== bench/allocator_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocator_checker
// Watches the request, result and register ports of the block allocator,
// keeps its own copy of the used map and the run table, predicts the result
// word of every accepted request and compares it with the words that leave.
// ----------------------------------------------------------------------------
module allocator_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [cffba_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [cffba_pkg::ACTION_W-1:0] in_action,
  input  logic [cffba_pkg::ID_W-1:0]     in_file_id,
  input  logic [cffba_pkg::LEN_W-1:0]    in_length,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [cffba_pkg::STATUS_W-1:0] out_status,
  input  logic [cffba_pkg::START_W-1:0]  out_start_block,
  output int                             mismatch_count,
  output int                             pending_words
);

  localparam int unsigned BLOCK_COUNT = 64;
  localparam int unsigned ID_COUNT    = 16;

  typedef struct packed {
    logic [cffba_pkg::STATUS_W-1:0] status;
    logic [cffba_pkg::START_W-1:0]  start;
  } grant_t;

  // shadow of the allocator state
  logic [BLOCK_COUNT-1:0]          used_map;
  logic [ID_COUNT-1:0]             id_held;
  logic [cffba_pkg::START_W-1:0]   run_start [ID_COUNT];
  logic [cffba_pkg::LEN_W-1:0]     run_len [ID_COUNT];
  logic [cffba_pkg::CFG_W-1:0]     managed_blocks;

  // result words still owed by the block, oldest first
  grant_t grant_q[$];

  // first-fit allocate or release, updates the shadow state
  function automatic grant_t predict_grant(input logic [cffba_pkg::ACTION_W-1:0] act,
                                           input logic [cffba_pkg::ID_W-1:0] id,
                                           input logic [cffba_pkg::LEN_W-1:0] len);
    grant_t res;
    int limit;
    int run;
    int first;
    int b;
    bit found;
    res.status = cffba_pkg::ST_OK;
    res.start = '0;
    found = 1'b0;
    first = 0;
    run = 0;
    if (act == cffba_pkg::ACT_ALLOC) begin
      if (id_held[id]) begin
        res.status = cffba_pkg::ST_IN_USE;
      end else begin
        limit = (managed_blocks > BLOCK_COUNT) ? BLOCK_COUNT : int'(managed_blocks);
        // lowest run of free blocks inside the managed range
        if (len != 0) begin
          for (b = 0; b < limit && !found; b++) begin
            if (!used_map[b]) begin
              run++;
              if (run == len) begin
                found = 1'b1;
                first = b + 1 - len;
              end
            end else begin
              run = 0;
            end
          end
        end
        if (!found) begin
          res.status = cffba_pkg::ST_NO_RUN;
        end else begin
          for (b = first; b < first + len && b < BLOCK_COUNT; b++) used_map[b] = 1'b1;
          id_held[id] = 1'b1;
          run_start[id] = first[cffba_pkg::START_W-1:0];
          run_len[id] = len;
          res.start = first[cffba_pkg::START_W-1:0];
        end
      end
    end else begin
      if (!id_held[id]) begin
        res.status = cffba_pkg::ST_NOT_HELD;
      end else begin
        // release the whole recorded run, managed or not
        first = run_start[id];
        for (b = first; b < first + run_len[id] && b < BLOCK_COUNT; b++) used_map[b] = 1'b0;
        id_held[id] = 1'b0;
        res.start = run_start[id];
      end
    end
    return res;
  endfunction

  // sample every channel at the rising edge
  always @(posedge clk) begin
    grant_t want;
    grant_t next_grant;
    if (!rst_n) begin
      used_map = '0;
      id_held = '0;
      managed_blocks = cffba_pkg::CFG_RESET;
      grant_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) managed_blocks = cfg_wr_data;
      // result word against the oldest prediction
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result word with none expected: status %0d start %0d",
                     $realtime, out_status, out_start_block);
          mismatch_count++;
        end else begin
          want = grant_q.pop_front();
          if (out_status !== want.status || out_start_block !== want.start) begin
            if (mismatch_count < 10)
              $display({"%0t: result word: expected status %0d start %0d,",
                        " got status %0d start %0d"},
                       $realtime, want.status, want.start, out_status, out_start_block);
            mismatch_count++;
          end
        end
      end
      // append the prediction for a newly accepted request
      if (in_valid && in_ready) begin
        next_grant = predict_grant(in_action, in_file_id, in_length);
        grant_q = {grant_q, next_grant};
      end
    end
    pending_words = grant_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the block allocator with a directed opening and then random phases
// under several managed block counts, with random gaps on both channels; the
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 80;
  localparam int PHASES      = 8;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [cffba_pkg::CFG_W-1:0]    cfg_wr_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [cffba_pkg::ACTION_W-1:0] in_action = cffba_pkg::ACT_ALLOC;
  logic [cffba_pkg::ID_W-1:0]     in_file_id = '0;
  logic [cffba_pkg::LEN_W-1:0]    in_length = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [cffba_pkg::STATUS_W-1:0] out_status;
  logic [cffba_pkg::START_W-1:0]  out_start_block;

  int  mismatch_count;
  int  pending_words;
  int  stall_cycles = 0;
  bit  steady = 1'b0;

  contiguous_first_fit_block_allocator_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_file_id     (in_file_id),
    .in_length      (in_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_start_block(out_start_block)
  );

  allocator_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_file_id     (in_file_id),
    .in_length      (in_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_start_block(out_start_block),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 30);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // present one request word, entered and left at a falling edge
  task automatic send_word(input logic [cffba_pkg::ACTION_W-1:0] act,
                           input logic [cffba_pkg::ID_W-1:0] id,
                           input logic [cffba_pkg::LEN_W-1:0] len);
    while (!steady && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_file_id <= id;
    in_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // hold requests until every result word is back
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
  endtask

  // register write, only with the block idle
  task automatic set_managed(input logic [cffba_pkg::CFG_W-1:0] count);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= count;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int phase_count [PHASES];
    logic [cffba_pkg::CFG_W-1:0] phase_cfg [PHASES];
    logic [cffba_pkg::ACTION_W-1:0] act;
    logic [cffba_pkg::LEN_W-1:0] len;
    int pick;

    phase_cfg = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd33, 7'd0, 7'd7, 7'd64};
    phase_count = '{250, 250, 80, 40, 250, 250, 150, 350};
    phase_cfg[5] = 7'($urandom_range(1, 64));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero, oversize and whole-store lengths at the reset count
    send_word(cffba_pkg::ACT_ALLOC, 4'd0, 7'd0);
    send_word(cffba_pkg::ACT_ALLOC, 4'd0, 7'd127);
    send_word(cffba_pkg::ACT_ALLOC, 4'd0, 7'd65);
    send_word(cffba_pkg::ACT_ALLOC, 4'd0, 7'd64);
    send_word(cffba_pkg::ACT_ALLOC, 4'd1, 7'd1);
    send_word(cffba_pkg::ACT_ALLOC, 4'd0, 7'd1);
    send_word(cffba_pkg::ACT_FREE, 4'd1, 7'd85);
    send_word(cffba_pkg::ACT_FREE, 4'd0, 7'd42);
    // fill, punch a hole, refill it first-fit
    send_word(cffba_pkg::ACT_ALLOC, 4'd15, 7'd10);
    send_word(cffba_pkg::ACT_ALLOC, 4'd1, 7'd20);
    send_word(cffba_pkg::ACT_ALLOC, 4'd2, 7'd34);
    send_word(cffba_pkg::ACT_FREE, 4'd1, 7'd0);
    send_word(cffba_pkg::ACT_ALLOC, 4'd3, 7'd21);
    send_word(cffba_pkg::ACT_ALLOC, 4'd3, 7'd5);
    send_word(cffba_pkg::ACT_ALLOC, 4'd4, 7'd15);
    send_word(cffba_pkg::ACT_FREE, 4'd15, 7'd0);
    // count lowered below held runs; free clears beyond the count
    set_managed(7'd20);
    send_word(cffba_pkg::ACT_ALLOC, 4'd5, 7'd11);
    send_word(cffba_pkg::ACT_FREE, 4'd2, 7'd0);
    set_managed(7'd0);
    send_word(cffba_pkg::ACT_ALLOC, 4'd6, 7'd1);
    // count above the store saturates
    set_managed(7'd127);
    send_word(cffba_pkg::ACT_ALLOC, 4'd6, 7'd34);
    send_word(cffba_pkg::ACT_FREE, 4'd3, 7'd0);
    send_word(cffba_pkg::ACT_FREE, 4'd4, 7'd0);
    send_word(cffba_pkg::ACT_FREE, 4'd6, 7'd0);
    send_word(cffba_pkg::ACT_ALLOC, 4'd7, 7'd64);
    send_word(cffba_pkg::ACT_FREE, 4'd7, 7'd0);
    set_managed(7'd1);
    send_word(cffba_pkg::ACT_ALLOC, 4'd8, 7'd1);
    send_word(cffba_pkg::ACT_ALLOC, 4'd9, 7'd1);
    send_word(cffba_pkg::ACT_FREE, 4'd8, 7'd0);

    // random phases, the last one without idling on either side
    for (int p = 0; p < PHASES; p++) begin
      set_managed(phase_cfg[p]);
      steady = (p == PHASES - 1);
      for (int i = 0; i < phase_count[p]; i++) begin
        if (p == 0 && i == phase_count[p] / 2) drain();
        act = ($urandom_range(0, 99) < 55) ? cffba_pkg::ACT_ALLOC : cffba_pkg::ACT_FREE;
        pick = $urandom_range(0, 99);
        if (act == cffba_pkg::ACT_FREE)
          len = 7'($urandom_range(0, 127));
        else if (pick < 70)
          len = 7'($urandom_range(1, 8));
        else if (pick < 90)
          len = 7'($urandom_range(9, 32));
        else if (pick < 97)
          len = 7'($urandom_range(33, 64));
        else
          len = (pick == 97) ? 7'd0 : 7'($urandom_range(65, 127));
        send_word(act, 4'($urandom_range(0, 15)), len);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
